// File: rtl/s20_pkg.sv
// Shared types and constants of the Salsa20/20 stream cipher core.
// Holds the configuration register codes, the engine states and the round schedule tables.
// No dependencies.
package s20_pkg;

    localparam int BYTE_W      = 8;
    localparam int WORD_W      = 32;
    localparam int NUM_WORDS   = 16;
    localparam int BLOCK_BYTES = 64;
    localparam int POS_W       = 7;
    localparam int STEP_W      = 7;
    localparam int ROUND_STEPS = 80;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 64;

    localparam logic [WORD_W-1:0] SIGMA0 = 32'h6170_7865;
    localparam logic [WORD_W-1:0] SIGMA1 = 32'h3320_646e;
    localparam logic [WORD_W-1:0] SIGMA2 = 32'h7962_2d32;
    localparam logic [WORD_W-1:0] SIGMA3 = 32'h6b20_6574;

    // Word indexes (a, b, c, d) of the four quarter rounds, column round then row round.
    localparam logic [3:0] QR_IDX [2][4][4] = '{
        '{'{4'd0,  4'd4,  4'd8,  4'd12},
          '{4'd5,  4'd9,  4'd13, 4'd1},
          '{4'd10, 4'd14, 4'd2,  4'd6},
          '{4'd15, 4'd3,  4'd7,  4'd11}},
        '{'{4'd0,  4'd1,  4'd2,  4'd3},
          '{4'd5,  4'd6,  4'd7,  4'd4},
          '{4'd10, 4'd11, 4'd8,  4'd9},
          '{4'd15, 4'd12, 4'd13, 4'd14}}
    };

    localparam int ROLE_A = 0;
    localparam int ROLE_B = 1;
    localparam int ROLE_C = 2;
    localparam int ROLE_D = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_KEY0  = 3'd0,
        CFG_KEY1  = 3'd1,
        CFG_KEY2  = 3'd2,
        CFG_KEY3  = 3'd3,
        CFG_NONCE = 3'd4,
        CFG_START = 3'd5
    } t_cfg_reg;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ROUND,
        ST_FINAL
    } t_state;

    typedef struct packed {
        logic [CFG_DATA_W-1:0] key0;
        logic [CFG_DATA_W-1:0] key1;
        logic [CFG_DATA_W-1:0] key2;
        logic [CFG_DATA_W-1:0] key3;
        logic [CFG_DATA_W-1:0] nonce;
        logic [CFG_DATA_W-1:0] start;
    } t_cfg;

    typedef struct packed {
        logic                  valid;
        logic [CFG_IDX_W-1:0]  index;
        logic [CFG_DATA_W-1:0] data;
    } t_cfg_wr;

    // Classified input: the byte to XOR onto the keystream (zero for raw keystream).
    typedef struct packed {
        logic [BYTE_W-1:0] operand;
    } t_item;

    typedef struct packed {
        logic gen_busy;
        logic buf_empty;
    } t_back_stat;

    function automatic logic [WORD_W-1:0] rotl32(input logic [WORD_W-1:0] v,
                                                 input int unsigned n);
        return (v << n) | (v >> (WORD_W - n));
    endfunction

endpackage

// File: rtl/s20_fifo.sv
// Small register-based queue of the Salsa20 core.
// Generic width and depth; used for the item queue and the result queue. No package use.
module s20_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    output logic             o_empty,
    output logic [WIDTH-1:0] o_data,
    input  logic             i_pop
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;
    logic             s_push_ok;
    logic             s_pop_ok;

    assign o_full    = (r_count == CNT_W'(DEPTH));
    assign o_empty   = (r_count == '0);
    assign o_data    = r_mem[r_rd_ptr];
    assign s_push_ok = i_push && !o_full;
    assign s_pop_ok  = i_pop && !o_empty;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (s_push_ok) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (s_pop_ok) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        case ({s_push_ok, s_pop_ok})
            2'b10:   n_count = r_count + 1'b1;
            2'b01:   n_count = r_count - 1'b1;
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_push_ok) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

// File: rtl/s20_front.sv
// Front end of the Salsa20 core: takes input bytes, classifies them, queues them.
// Depends on s20_pkg and s20_fifo.
module s20_front import s20_pkg::*; #(
    parameter int DEPTH = 2
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    output logic              o_full,
    input  logic [BYTE_W-1:0] i_data_byte,
    input  logic              i_keystream_only,
    output logic              o_valid,
    output t_item             o_item,
    input  logic              i_take
);

    t_item                     s_item;
    logic [$bits(t_item)-1:0]  s_q_data;
    logic                      s_q_empty;

    // Raw keystream requests XOR with zero.
    assign s_item.operand = i_keystream_only ? '0 : i_data_byte;

    s20_fifo #(
        .WIDTH ($bits(t_item)),
        .DEPTH (DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_push),
        .i_data  (s_item),
        .o_full  (o_full),
        .o_empty (s_q_empty),
        .o_data  (s_q_data),
        .i_pop   (i_take)
    );

    assign o_valid = !s_q_empty;
    assign o_item  = t_item'(s_q_data);

endmodule

// File: rtl/s20_back.sv
// Back end of the Salsa20 core: configuration registers, round engine and keystream buffer.
// Depends on s20_pkg.
module s20_back import s20_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cfg_wr           i_cfg_wr,
    input  logic              i_item_valid,
    input  t_item             i_item,
    output logic              o_item_take,
    input  logic              i_out_full,
    output logic              o_out_push,
    output logic [BYTE_W-1:0] o_out_byte,
    output t_back_stat        o_stat
);

    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(ROUND_STEPS - 1);
    localparam logic [POS_W-1:0]  POS_EMPTY = POS_W'(BLOCK_BYTES);

    t_state              r_state, n_state;
    t_cfg                r_cfg, n_cfg;
    logic [63:0]         r_ctr, n_ctr;
    logic [POS_W-1:0]    r_pos, n_pos;
    logic [STEP_W-1:0]   r_step, n_step;
    logic [WORD_W-1:0]   r_words     [NUM_WORDS];
    logic [WORD_W-1:0]   n_words     [NUM_WORDS];
    logic [WORD_W-1:0]   start_words [NUM_WORDS];
    logic [WORD_W-1:0]   step_words  [NUM_WORDS];

    logic [3:0]          q_src1 [4];
    logic [3:0]          q_src2 [4];
    logic [3:0]          q_dst  [4];
    logic [WORD_W-1:0]   q_sum  [4];
    logic [WORD_W-1:0]   q_rot  [4];

    logic                s_cfg_hit;
    logic                s_load;
    logic                s_emit;
    logic                s_step;
    logic                s_final;
    logic [WORD_W-1:0]   s_ks_word;
    logic [BYTE_W-1:0]   s_ks_byte;

    // Configuration decode; an index beyond the list changes nothing.
    always_comb begin
        n_cfg     = r_cfg;
        s_cfg_hit = 1'b0;
        if (i_cfg_wr.valid) begin
            case (i_cfg_wr.index)
                CFG_KEY0:  begin n_cfg.key0  = i_cfg_wr.data; s_cfg_hit = 1'b1; end
                CFG_KEY1:  begin n_cfg.key1  = i_cfg_wr.data; s_cfg_hit = 1'b1; end
                CFG_KEY2:  begin n_cfg.key2  = i_cfg_wr.data; s_cfg_hit = 1'b1; end
                CFG_KEY3:  begin n_cfg.key3  = i_cfg_wr.data; s_cfg_hit = 1'b1; end
                CFG_NONCE: begin n_cfg.nonce = i_cfg_wr.data; s_cfg_hit = 1'b1; end
                CFG_START: begin n_cfg.start = i_cfg_wr.data; s_cfg_hit = 1'b1; end
                default:   s_cfg_hit = 1'b0;
            endcase
        end
    end

    always_comb begin
        start_words[0]  = SIGMA0;
        start_words[1]  = r_cfg.key0[31:0];
        start_words[2]  = r_cfg.key0[63:32];
        start_words[3]  = r_cfg.key1[31:0];
        start_words[4]  = r_cfg.key1[63:32];
        start_words[5]  = SIGMA1;
        start_words[6]  = r_cfg.nonce[31:0];
        start_words[7]  = r_cfg.nonce[63:32];
        start_words[8]  = r_ctr[31:0];
        start_words[9]  = r_ctr[63:32];
        start_words[10] = SIGMA2;
        start_words[11] = r_cfg.key2[31:0];
        start_words[12] = r_cfg.key2[63:32];
        start_words[13] = r_cfg.key3[31:0];
        start_words[14] = r_cfg.key3[63:32];
        start_words[15] = SIGMA3;
    end

    // One line of all four quarter rounds per cycle; the four touch disjoint words.
    always_comb begin
        step_words = r_words;
        for (int q = 0; q < 4; q++) begin
            case (r_step[1:0])
                2'd0: begin
                    q_src1[q] = QR_IDX[r_step[2]][q][ROLE_A];
                    q_src2[q] = QR_IDX[r_step[2]][q][ROLE_D];
                    q_dst[q]  = QR_IDX[r_step[2]][q][ROLE_B];
                end
                2'd1: begin
                    q_src1[q] = QR_IDX[r_step[2]][q][ROLE_B];
                    q_src2[q] = QR_IDX[r_step[2]][q][ROLE_A];
                    q_dst[q]  = QR_IDX[r_step[2]][q][ROLE_C];
                end
                2'd2: begin
                    q_src1[q] = QR_IDX[r_step[2]][q][ROLE_C];
                    q_src2[q] = QR_IDX[r_step[2]][q][ROLE_B];
                    q_dst[q]  = QR_IDX[r_step[2]][q][ROLE_D];
                end
                default: begin
                    q_src1[q] = QR_IDX[r_step[2]][q][ROLE_D];
                    q_src2[q] = QR_IDX[r_step[2]][q][ROLE_C];
                    q_dst[q]  = QR_IDX[r_step[2]][q][ROLE_A];
                end
            endcase
            q_sum[q] = r_words[q_src1[q]] + r_words[q_src2[q]];
            case (r_step[1:0])
                2'd0:    q_rot[q] = rotl32(q_sum[q], 7);
                2'd1:    q_rot[q] = rotl32(q_sum[q], 9);
                2'd2:    q_rot[q] = rotl32(q_sum[q], 13);
                default: q_rot[q] = rotl32(q_sum[q], 18);
            endcase
            step_words[q_dst[q]] = r_words[q_dst[q]] ^ q_rot[q];
        end
    end

    assign s_ks_word = r_words[r_pos[5:2]];
    assign s_ks_byte = s_ks_word[{r_pos[1:0], 3'b000} +: BYTE_W];

    // Next state.
    always_comb begin
        n_state = r_state;
        if (s_cfg_hit) begin
            n_state = ST_IDLE;
        end else begin
            case (r_state)
                ST_IDLE: begin
                    if (i_item_valid && r_pos[POS_W-1]) begin
                        n_state = ST_ROUND;
                    end
                end
                ST_ROUND: begin
                    if (r_step == LAST_STEP) begin
                        n_state = ST_FINAL;
                    end
                end
                ST_FINAL: n_state = ST_IDLE;
                default:  n_state = ST_IDLE;
            endcase
        end
    end

    // Control outputs.
    always_comb begin
        s_load  = 1'b0;
        s_emit  = 1'b0;
        s_step  = 1'b0;
        s_final = 1'b0;
        case (r_state)
            ST_IDLE: begin
                s_load = !s_cfg_hit && i_item_valid && r_pos[POS_W-1];
                s_emit = !s_cfg_hit && i_item_valid && !r_pos[POS_W-1] && !i_out_full;
            end
            ST_ROUND: s_step  = 1'b1;
            ST_FINAL: s_final = !s_cfg_hit;
            default: begin
                s_load = 1'b0;
            end
        endcase
    end

    always_comb begin
        n_words = r_words;
        if (s_load) begin
            n_words = start_words;
        end else if (s_step) begin
            n_words = step_words;
        end else if (s_final) begin
            for (int i = 0; i < NUM_WORDS; i++) begin
                n_words[i] = r_words[i] + start_words[i];
            end
        end
    end

    always_comb begin
        n_step = r_step;
        n_pos  = r_pos;
        n_ctr  = r_ctr;
        if (s_load) begin
            n_step = '0;
        end else if (s_step) begin
            n_step = r_step + 1'b1;
        end
        if (s_cfg_hit) begin
            n_pos = POS_EMPTY;
            n_ctr = n_cfg.start;
        end else if (s_final) begin
            n_pos = '0;
            n_ctr = r_ctr + 64'd1;
        end else if (s_emit) begin
            n_pos = r_pos + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cfg   <= '0;
            r_ctr   <= '0;
            r_pos   <= POS_EMPTY;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_cfg   <= n_cfg;
            r_ctr   <= n_ctr;
            r_pos   <= n_pos;
            r_step  <= n_step;
        end
    end

    always_ff @(posedge i_clk) begin
        r_words <= n_words;
    end

    assign o_item_take      = s_emit;
    assign o_out_push       = s_emit;
    assign o_out_byte       = i_item.operand ^ s_ks_byte;
    assign o_stat.gen_busy  = (r_state != ST_IDLE);
    assign o_stat.buf_empty = r_pos[POS_W-1];

endmodule

// File: rtl/salsa20_stream_cipher_core.sv
// Salsa20/20 stream cipher core, top level.
// Depends on s20_pkg, s20_front, s20_back and s20_fifo.
//
// Byte-wide Salsa20/20 encrypt/decrypt engine with queue-style ports on both sides.
// Each accepted byte comes back XORed with the next keystream byte, or as the raw
// keystream byte when i_keystream_only is set; results leave in input order.
// A byte is served from the 64-byte keystream buffer while the buffer holds data
// and the result queue has room. When the buffer runs dry the round engine builds
// the next block: it loads the start state, runs the ten double rounds (one line
// of the four quarter rounds per cycle, a 32-bit add, rotate and XOR), then does
// the final add; no byte is served meanwhile. Generation starts only when a byte
// is waiting for it. Bytes pass through the item queue, the engine and the result
// queue; both queues are registered, and the engine's byte path is combinational.
// The configuration channel is always ready. Registers 0 to 3 carry key bytes 0-31
// (little-endian, low word first), 4 the nonce, 5 the start counter. Any write to
// one of them reloads the block counter from the start counter and empties the
// buffer; writes to other indexes are dropped. Write configuration only while the
// core holds no pending bytes. The block counter wraps modulo 2^64.
module salsa20_stream_cipher_core import s20_pkg::*; #(
    parameter int IN_QUEUE_DEPTH  = 2,
    parameter int OUT_QUEUE_DEPTH = 2
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // item side
    input  logic                  push,
    output logic                  full,
    input  logic [BYTE_W-1:0]     i_data_byte,
    input  logic                  i_keystream_only,
    // result side
    output logic                  empty,
    input  logic                  pop,
    output logic [BYTE_W-1:0]     o_out_byte,
    // configuration writes
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cfg_wr           cfg_wr;
    logic              item_valid;
    t_item             item;
    logic              item_take;
    logic              out_full;
    logic              back_push;
    logic [BYTE_W-1:0] back_byte;
    t_back_stat        back_stat;

    // Accept every configuration write at once.
    assign o_cfg_ready  = 1'b1;
    assign cfg_wr.valid = i_cfg_valid;
    assign cfg_wr.index = i_cfg_index;
    assign cfg_wr.data  = i_cfg_data;

    // Classify and queue incoming bytes.
    s20_front #(
        .DEPTH (IN_QUEUE_DEPTH)
    ) u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_push           (push),
        .o_full           (full),
        .i_data_byte      (i_data_byte),
        .i_keystream_only (i_keystream_only),
        .o_valid          (item_valid),
        .o_item           (item),
        .i_take           (item_take)
    );

    // Generate keystream and combine it with queued bytes.
    s20_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_wr     (cfg_wr),
        .i_item_valid (item_valid),
        .i_item       (item),
        .o_item_take  (item_take),
        .i_out_full   (out_full),
        .o_out_push   (back_push),
        .o_out_byte   (back_byte),
        .o_stat       (back_stat)
    );

    // Hold finished results until the consumer pops them.
    s20_fifo #(
        .WIDTH (BYTE_W),
        .DEPTH (OUT_QUEUE_DEPTH)
    ) u_out_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (back_push),
        .i_data  (back_byte),
        .o_full  (out_full),
        .o_empty (empty),
        .o_data  (o_out_byte),
        .i_pop   (pop)
    );

`ifndef SYNTHESIS
    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        back_push |-> !out_full)
        else $error("result pushed into a full result queue");

    a_take_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        item_take |-> item_valid)
        else $error("engine took an item from an empty item queue");

    a_no_emit_gen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        back_push |-> (!back_stat.gen_busy && !back_stat.buf_empty))
        else $error("result produced without a ready keystream block");

    a_cfg_flush: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cfg_valid && o_cfg_ready && i_cfg_index <= CFG_START)
        |=> (back_stat.buf_empty && !back_stat.gen_busy))
        else $error("configuration write did not empty the keystream buffer");
`endif

endmodule
